// ===== rtl/ppf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_pkg: shared types and constants of the pairwise particle force unit
// Field widths, fixed-point constants and the divider sideband type.
// ----------------------------------------------------------------------------
package ppf_pkg;

  localparam int TYPE_W    = 5;
  localparam int DIST_W    = 20;
  localparam int CODE_W    = 3;
  localparam int SCALE_W   = 16;
  localparam int FMAX_W    = 16;
  localparam int ENTRY_W   = CODE_W + 1 + SCALE_W;
  localparam int RADIUS_W  = SCALE_W + DIST_W;   // Q20.16 effective radius
  localparam int QUOT_W    = 17;                 // normalized distance, 0..65536
  localparam int FORCE_W   = 17;
  localparam int CURVE_W   = 18;                 // signed Q1.16 curve value
  localparam int CFG_IDX_W = 1;

  localparam int DEF_MAX_TYPES       = 32;
  localparam int DEF_SINE_DEPTH      = 256;
  localparam int DEF_MOUNTAIN_DEPTH  = 256;

  localparam logic [DIST_W-1:0] RADIUS_MAX_RST = 20'd128000;
  localparam logic [FMAX_W-1:0] FORCE_MAX_RST  = 16'd13107;

  localparam longint unsigned ONE_Q30    = 64'd1073741824;
  localparam longint unsigned HALFPI_Q30 = 64'd1686629713;
  localparam int              ONE_Q16    = 65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_MAX = 1'b0,
    CFG_FORCE_MAX  = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_WRITE = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [CODE_W-1:0] {
    CURVE_CONST    = 3'd0,
    CURVE_FALLING  = 3'd1,
    CURVE_RISING   = 3'd2,
    CURVE_NEG_SINE = 3'd3,
    CURVE_DOUBLE   = 3'd4,
    CURVE_MOUNTAIN = 3'd5
  } curve_t;

  // Control that rides along the divider pipeline.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              sign;
    logic              beyond;
    logic              in_range;
  } div_side_t;

endpackage : ppf_pkg
`default_nettype wire

// ===== rtl/ppf_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppf_divider: pipelined restoring divider
// One quotient bit per stage, floor(dist * 2^32 / radius), 17 bits.
// ----------------------------------------------------------------------------
module ppf_divider (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [ppf_pkg::DIST_W-1:0]    in_dist,
  input  wire logic [ppf_pkg::RADIUS_W-1:0]  in_den,
  input  wire ppf_pkg::div_side_t            in_side,
  output logic                               out_valid,
  output logic [ppf_pkg::QUOT_W-1:0]         out_quot,
  output ppf_pkg::div_side_t                 out_side
);
  import ppf_pkg::*;

  localparam int NSTG = QUOT_W;

  logic                 vld_r  [NSTG+1];
  logic [RADIUS_W-1:0]  rem_r  [NSTG+1];
  logic [RADIUS_W-1:0]  den_r  [NSTG+1];
  logic [QUOT_W-1:0]    quot_r [NSTG+1];
  div_side_t            side_r [NSTG+1];

  // entry stage: remainder starts at dist * 2^15, below radius when in range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= RADIUS_W'({in_dist, 15'd0});
      den_r[0]  <= in_den;
      quot_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < NSTG; s++) begin : g_stage
    logic [RADIUS_W:0] trial;
    logic              ge;
    logic [RADIUS_W:0] diff;

    assign trial = {rem_r[s], 1'b0};
    assign ge    = trial >= {1'b0, den_r[s]};
    assign diff  = trial - {1'b0, den_r[s]};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? diff[RADIUS_W-1:0] : trial[RADIUS_W-1:0];
        den_r[s+1]  <= den_r[s];
        quot_r[s+1] <= {quot_r[s][QUOT_W-2:0], ge};
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = vld_r[NSTG];
  assign out_quot  = quot_r[NSTG];
  assign out_side  = side_r[NSTG];

endmodule : ppf_divider
`default_nettype wire

// ===== rtl/pairwise_particle_force_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_particle_force_unit: particle-life pairwise force evaluator
// Pair table of curve/sign/radius scale per type pair; queries return force.
// ----------------------------------------------------------------------------
// One request per cycle enters the pipeline while it advances, writes and
// queries alike. A query's result is presented in the output register. The
// path has 24 registers, and the first is loaded by the edge that takes the
// request: table read, radius multiply, the divider (entry register plus
// 17 one-bit-per-stage registers), curve table index, curve lookup, force
// multiply and the output register. Write requests (tuser = 0) only update
// the pair table and give no result. The whole pipeline advances when the
// output register is empty or being taken, so back-pressure on out_tready
// holds every stage in place. A query that reads a table entry never
// written returns undefined data. Configuration writes are accepted at any
// time but must only be issued while no query is in flight.
// ----------------------------------------------------------------------------
module pairwise_particle_force_unit #(
  parameter int MAX_TYPES            = ppf_pkg::DEF_MAX_TYPES,
  parameter int SINE_TABLE_DEPTH     = ppf_pkg::DEF_SINE_DEPTH,
  parameter int MOUNTAIN_TABLE_DEPTH = ppf_pkg::DEF_MOUNTAIN_DEPTH
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // request stream
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [4:0] source_type, [9:5] target_type, [29:10] distance,
  // [32:30] curve_code, [33] sign_bit, [49:34] radius_scale, [55:50] zero
  input  wire logic [55:0]                    in_tdata,
  // [0] kind
  input  wire logic                           in_tuser,
  // result stream
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [16:0] force_res, [17] beyond_radius, [23:18] zero
  output logic [23:0]                         out_tdata,
  // configuration
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ppf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ppf_pkg::DIST_W-1:0]     cfg_data
);
  import ppf_pkg::*;

  localparam int SLOTS  = MAX_TYPES * MAX_TYPES;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIDX_W = $clog2(SINE_TABLE_DEPTH);
  localparam int MIDX_W = $clog2(MOUNTAIN_TABLE_DEPTH);
  localparam int SPW    = QUOT_W + $clog2(SINE_TABLE_DEPTH + 1);
  localparam int MPW    = QUOT_W + $clog2(MOUNTAIN_TABLE_DEPTH + 1);

  // ---------------- constant curve tables ----------------
  logic signed [CURVE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
  logic signed [CURVE_W-1:0] mtn_rom  [MOUNTAIN_TABLE_DEPTH];

  // -sin(2*pi*k/D): quadrant fold, odd Taylor series to x^11 in Q30
  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_sine
    localparam longint unsigned Four = 4 * k;
    localparam longint unsigned Quad = Four / SINE_TABLE_DEPTH;
    localparam longint unsigned Rm   = Four - Quad * SINE_TABLE_DEPTH;
    localparam longint unsigned Num  = (Quad % 2 == 1) ? (SINE_TABLE_DEPTH - Rm) : Rm;
    localparam longint unsigned Xv   = Num * HALFPI_Q30 / SINE_TABLE_DEPTH;
    localparam longint unsigned X2   = (Xv * Xv) >> 30;
    localparam longint unsigned T1   = ONE_Q30 - ((X2 * ONE_Q30) >> 30) / 110;
    localparam longint unsigned T2   = ONE_Q30 - ((X2 * T1) >> 30) / 72;
    localparam longint unsigned T3   = ONE_Q30 - ((X2 * T2) >> 30) / 42;
    localparam longint unsigned T4   = ONE_Q30 - ((X2 * T3) >> 30) / 20;
    localparam longint unsigned T5   = ONE_Q30 - ((X2 * T4) >> 30) / 6;
    localparam longint unsigned Sv   = (Xv * T5) >> 30;
    localparam longint unsigned Vv   = (Sv + 8192) >> 14;
    assign sine_rom[k] = (Quad >= 2) ? CURVE_W'(Vv) : CURVE_W'(0) - CURVE_W'(Vv);
  end

  // mountain: 2(D^2-u^2)/(5u^2+2D^2), u = 2k-D, rounded half up
  for (genvar k = 0; k < MOUNTAIN_TABLE_DEPTH; k++) begin : g_mtn
    localparam longint Dd   = MOUNTAIN_TABLE_DEPTH;
    localparam longint Uv   = 2 * k - Dd;
    localparam longint MNum = (Dd * Dd - Uv * Uv) * 131072;
    localparam longint MDen = 5 * Uv * Uv + 2 * Dd * Dd;
    localparam longint Mv   = (2 * MNum + MDen) / (2 * MDen);
    assign mtn_rom[k] = CURVE_W'(Mv);
  end

  // ---------------- configuration ----------------
  logic [DIST_W-1:0] radius_max_r;
  logic [FMAX_W-1:0] force_max_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_max_r <= RADIUS_MAX_RST;
      force_max_r  <= FORCE_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RADIUS_MAX: radius_max_r <= cfg_data;
        CFG_FORCE_MAX:  force_max_r  <= cfg_data[FMAX_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- global advance ----------------
  logic out_valid_r;
  logic en;
  logic accept;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign accept    = in_tvalid && en;

  // ---------------- request decode ----------------
  logic [TYPE_W-1:0]  src, dst;
  logic [DIST_W-1:0]  dist_in;
  logic [ENTRY_W-1:0] wr_entry;
  logic [11:0]        slot_full;
  logic [SLOT_W-1:0]  slot;
  logic               in_range;

  assign src       = in_tdata[4:0];
  assign dst       = in_tdata[9:5];
  assign dist_in   = in_tdata[29:10];
  assign wr_entry  = in_tdata[49:30];   // {scale, sign, code} -> repacked below
  assign slot_full = 12'(src) * 12'(MAX_TYPES) + 12'(dst);
  assign slot      = slot_full[SLOT_W-1:0];
  assign in_range  = (7'(src) < 7'(MAX_TYPES)) && (7'(dst) < 7'(MAX_TYPES));

  // pair table: bits 19..17 curve, 16 sign, 15..0 radius scale
  logic [ENTRY_W-1:0] pair_mem [SLOTS];
  logic [ENTRY_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (accept && in_tuser == KIND_WRITE && in_range) begin
      pair_mem[slot] <= {wr_entry[CODE_W-1:0], wr_entry[CODE_W], wr_entry[ENTRY_W-1:CODE_W+1]};
    end
    if (en) begin
      entry_r <= pair_mem[slot];
    end
  end

  // ---------------- stage 1: table read ----------------
  logic              v1_r, rng1_r;
  logic [DIST_W-1:0] dist1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= accept && in_tuser == KIND_QUERY;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist1_r <= dist_in;
      rng1_r  <= in_range;
    end
  end

  // ---------------- stage 2: effective radius ----------------
  logic                v2_r, rng2_r, sign2_r;
  logic [DIST_W-1:0]   dist2_r;
  logic [CODE_W-1:0]   code2_r;
  logic [RADIUS_W-1:0] radius2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist2_r   <= dist1_r;
      rng2_r    <= rng1_r;
      code2_r   <= entry_r[ENTRY_W-1:ENTRY_W-CODE_W];
      sign2_r   <= entry_r[SCALE_W];
      radius2_r <= RADIUS_W'(entry_r[SCALE_W-1:0]) * RADIUS_W'(radius_max_r);
    end
  end

  // beyond when radius is zero or dist*2^16 exceeds it
  div_side_t side2;
  assign side2.code     = code2_r;
  assign side2.sign     = sign2_r;
  assign side2.in_range = rng2_r;
  assign side2.beyond   = (radius2_r == '0) || ({dist2_r, 16'd0} > radius2_r);

  // ---------------- divider ----------------
  logic              vd;
  logic [QUOT_W-1:0] quot;
  div_side_t         sided;

  ppf_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v2_r),
    .in_dist   (dist2_r),
    .in_den    (radius2_r),
    .in_side   (side2),
    .out_valid (vd),
    .out_quot  (quot),
    .out_side  (sided)
  );

  // ---------------- stage 4: table index ----------------
  logic [SPW-1:0]    sprod;
  logic [MPW-1:0]    mprod;
  logic [SPW-17:0]   sfull;
  logic [MPW-17:0]   mfull;
  logic [SIDX_W-1:0] sidx_r;
  logic [MIDX_W-1:0] midx_r;
  logic              v4_r;
  logic [QUOT_W-1:0] r4_r;
  div_side_t         side4_r;

  assign sprod = SPW'(quot) * SPW'(SINE_TABLE_DEPTH);
  assign mprod = MPW'(quot) * MPW'(MOUNTAIN_TABLE_DEPTH);
  assign sfull = sprod[SPW-1:16];
  assign mfull = mprod[MPW-1:16];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en) begin
      v4_r <= vd;
    end
  end

  // r of exactly one wraps to index zero
  always_ff @(posedge clk) begin
    if (en) begin
      r4_r    <= quot;
      side4_r <= sided;
      sidx_r  <= (sfull >= (SPW-16)'(SINE_TABLE_DEPTH)) ?
                 SIDX_W'(sfull - (SPW-16)'(SINE_TABLE_DEPTH)) : SIDX_W'(sfull);
      midx_r  <= (mfull >= (MPW-16)'(MOUNTAIN_TABLE_DEPTH)) ?
                 MIDX_W'(mfull - (MPW-16)'(MOUNTAIN_TABLE_DEPTH)) : MIDX_W'(mfull);
    end
  end

  // ---------------- stage 5: curve value ----------------
  logic signed [CURVE_W-1:0] fval;
  logic signed [CURVE_W-1:0] r_s;
  logic [QUOT_W-1:0]         fmag;
  logic                      v5_r, neg5_r, zero5_r, beyond5_r;
  logic [QUOT_W-1:0]         mag5_r;

  assign r_s = CURVE_W'(r4_r);

  always_comb begin
    unique case (side4_r.code)
      CURVE_CONST:    fval = CURVE_W'(ONE_Q16);
      CURVE_FALLING:  fval = CURVE_W'(ONE_Q16) - r_s;
      CURVE_RISING:   fval = r_s;
      CURVE_NEG_SINE: fval = sine_rom[sidx_r];
      CURVE_DOUBLE:   fval = (r_s <<< 1) - CURVE_W'(ONE_Q16);
      CURVE_MOUNTAIN: fval = mtn_rom[midx_r];
      default:        fval = '0;
    endcase
  end

  assign fmag = fval[CURVE_W-1] ? QUOT_W'(-fval) : QUOT_W'(fval);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag5_r    <= fmag;
      neg5_r    <= fval[CURVE_W-1] ^ !side4_r.sign;
      beyond5_r <= side4_r.beyond && side4_r.in_range;
      zero5_r   <= side4_r.beyond || !side4_r.in_range;
    end
  end

  // ---------------- stage 6: scale by force_max ----------------
  logic                      v6_r, neg6_r, zero6_r, beyond6_r;
  logic [QUOT_W+FMAX_W-1:0]  prod6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (en) begin
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod6_r   <= (QUOT_W+FMAX_W)'(mag5_r) * (QUOT_W+FMAX_W)'(force_max_r);
      neg6_r    <= neg5_r;
      zero6_r   <= zero5_r;
      beyond6_r <= beyond5_r;
    end
  end

  // ---------------- stage 7: round, saturate, sign ----------------
  logic [QUOT_W+FMAX_W:0] rsum;
  logic [FMAX_W-1:0]      mag_sat;
  logic [FORCE_W-1:0]     force_nxt;
  logic [FORCE_W-1:0]     force_r;
  logic                   beyond_r;

  assign rsum      = (QUOT_W+FMAX_W+1)'(prod6_r) + (QUOT_W+FMAX_W+1)'(32768);
  assign mag_sat   = (rsum[QUOT_W+FMAX_W:16] > (QUOT_W+1)'(16'hFFFF)) ?
                     16'hFFFF : rsum[31:16];
  assign force_nxt = zero6_r ? '0 :
                     neg6_r  ? FORCE_W'(0) - {1'b0, mag_sat} : {1'b0, mag_sat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      force_r  <= force_nxt;
      beyond_r <= beyond6_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, beyond_r, force_r};

endmodule : pairwise_particle_force_unit
`default_nettype wire
